>>> sv/nss_pkg.sv
package nss_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // Fixed field widths.
  localparam int ADDR_W      = 32;
  localparam int ENTRY_IDX_W = 10;
  localparam int COUNT_W     = 11;
  localparam int CFG_IDX_W   = 2;

  // Operation codes carried in the op field.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENTRY_COUNT = 2'd0,
    REG_TEXT_START  = 2'd1,
    REG_TEXT_END    = 2'd2
  } cfg_reg_t;

  // Search sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                   op;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic [ADDR_W-1:0]      entry_address;
    logic [ADDR_W-1:0]      query_address;
  } in_word_t;

  typedef struct packed {
    logic                   found;
    logic [ENTRY_IDX_W-1:0] match_index;
    logic [ADDR_W-1:0]      offset;
  } out_word_t;

  typedef struct packed {
    logic [COUNT_W-1:0] entry_count;
    logic [ADDR_W-1:0]  text_start;
    logic [ADDR_W-1:0]  text_end;
  } cfg_t;

  // Access request from the sequencer to the address table.
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [ADDR_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } ram_req_t;

endpackage

>>> sv/nss_ram.sv
module nss_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/nss_search.sv
module nss_search (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  nss_pkg::in_word_t    in_word,
  input  nss_pkg::cfg_t        cfg,
  output nss_pkg::ram_req_t    ram_req,
  input  logic [nss_pkg::ADDR_W-1:0] ram_rdata,
  output logic                 out_valid,
  input  logic                 out_stall,
  output nss_pkg::out_word_t   out_word
);

  nss_pkg::state_t state_r, state_nxt;

  logic [nss_pkg::ADDR_W-1:0] query_r;
  logic [nss_pkg::CNT_W-1:0]  limit_r;
  logic [nss_pkg::IDX_W-1:0]  cmp_idx_r;
  logic                       hit_r;
  logic [nss_pkg::IDX_W-1:0]  best_idx_r;
  logic [nss_pkg::ADDR_W-1:0] best_dist_r;
  logic                       out_valid_r;
  nss_pkg::out_word_t         out_word_r;

  logic                       in_acc;
  logic                       is_query;
  logic                       in_window;
  logic                       idx_ok;
  logic [nss_pkg::CNT_W-1:0]  limit_in;
  logic                       last_cmp;
  logic [nss_pkg::ADDR_W-1:0] distance;
  logic                       cand;
  logic                       out_free;

  // Decode of the incoming word and the window test.
  assign in_acc    = in_valid && !in_stall;
  assign is_query  = (in_word.op == nss_pkg::OP_QUERY);
  assign in_window = (in_word.query_address >= cfg.text_start) &&
                     (in_word.query_address < cfg.text_end);
  assign idx_ok    = (32'(in_word.entry_index) < 32'(nss_pkg::TABLE_DEPTH));
  assign limit_in  = (32'(cfg.entry_count) > 32'(nss_pkg::TABLE_DEPTH)) ?
                     nss_pkg::CNT_W'(nss_pkg::TABLE_DEPTH) :
                     nss_pkg::CNT_W'(cfg.entry_count);

  // Compare of the entry read in the previous cycle against the best so far.
  assign last_cmp = (nss_pkg::CNT_W'(cmp_idx_r) + nss_pkg::CNT_W'(1)) == limit_r;
  assign distance = query_r - ram_rdata;
  assign cand     = (ram_rdata <= query_r) && (!hit_r || (distance < best_dist_r));
  assign out_free = !out_valid_r || !out_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nss_pkg::S_IDLE: begin
        if (in_acc && is_query) begin
          if (in_window && (limit_in != '0)) begin
            state_nxt = nss_pkg::S_SCAN;
          end else begin
            state_nxt = nss_pkg::S_DONE;
          end
        end
      end
      nss_pkg::S_SCAN: begin
        if (last_cmp) begin
          state_nxt = nss_pkg::S_DONE;
        end
      end
      nss_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = nss_pkg::S_IDLE;
        end
      end
      default: state_nxt = nss_pkg::S_IDLE;
    endcase
  end

  // Handshake and table access for each state.
  always_comb begin
    in_stall      = 1'b1;
    ram_req.we    = 1'b0;
    ram_req.waddr = nss_pkg::IDX_W'(in_word.entry_index);
    ram_req.wdata = in_word.entry_address;
    ram_req.re    = 1'b0;
    ram_req.raddr = '0;
    case (state_r)
      nss_pkg::S_IDLE: begin
        in_stall   = 1'b0;
        ram_req.we = in_acc && !is_query && idx_ok;
        ram_req.re = in_acc && is_query;
      end
      nss_pkg::S_SCAN: begin
        ram_req.re    = !last_cmp;
        ram_req.raddr = cmp_idx_r + nss_pkg::IDX_W'(1);
      end
      nss_pkg::S_DONE: begin
        in_stall = 1'b1;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nss_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Scan datapath: set up on a query word, then one entry per cycle.
  always_ff @(posedge clk) begin
    if (state_r == nss_pkg::S_IDLE) begin
      if (in_acc && is_query) begin
        query_r     <= in_word.query_address;
        limit_r     <= limit_in;
        cmp_idx_r   <= '0;
        hit_r       <= 1'b0;
        best_idx_r  <= '0;
        best_dist_r <= in_window ? '1 : '0;
      end
    end else if (state_r == nss_pkg::S_SCAN) begin
      cmp_idx_r <= cmp_idx_r + nss_pkg::IDX_W'(1);
      if (cand) begin
        hit_r       <= 1'b1;
        best_idx_r  <= cmp_idx_r;
        best_dist_r <= distance;
      end
    end
  end

  // Output register: the result waits here while the consumer stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == nss_pkg::S_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == nss_pkg::S_DONE) && out_free) begin
      out_word_r.found       <= hit_r;
      out_word_r.match_index <= nss_pkg::ENTRY_IDX_W'(best_idx_r);
      out_word_r.offset      <= best_dist_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

>>> sv/nearest_symbol_search.sv
// Channel   Direction  Handshake            Word
// in_       input      in_valid / in_stall  nss_pkg::in_word_t (load or query)
// out_      output     out_valid / out_stall nss_pkg::out_word_t (one per query)
// cfg_      input      cfg_we               cfg_index, cfg_wdata (no read-back)
//
// A load word writes the address table directly; the block stays ready.
// A query scans entry_count entries (capped at the table depth) through
// the single read port of the table, which is read one entry per cycle.
// A query outside the text window, or with no entries, skips the scan.
// Reset is synchronous, active low; the table itself is not cleared.
// A stalled result is held in the output register; a new word is taken
// once the finished result has moved into that register.
module nearest_symbol_search (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  nss_pkg::in_word_t               in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output nss_pkg::out_word_t              out_word,
  input  logic                            cfg_we,
  input  logic [nss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nss_pkg::ADDR_W-1:0]      cfg_wdata
);

  nss_pkg::cfg_t              cfg_r;
  nss_pkg::ram_req_t          ram_req;
  logic [nss_pkg::ADDR_W-1:0] ram_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (nss_pkg::cfg_reg_t'(cfg_index))
        nss_pkg::REG_ENTRY_COUNT: cfg_r.entry_count <= nss_pkg::COUNT_W'(cfg_wdata);
        nss_pkg::REG_TEXT_START:  cfg_r.text_start  <= cfg_wdata;
        nss_pkg::REG_TEXT_END:    cfg_r.text_end    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Address table.
  nss_ram #(
    .DEPTH(nss_pkg::TABLE_DEPTH),
    .WIDTH(nss_pkg::ADDR_W)
  ) u_table (
    .clk  (clk),
    .we   (ram_req.we),
    .waddr(ram_req.waddr),
    .wdata(ram_req.wdata),
    .re   (ram_req.re),
    .raddr(ram_req.raddr),
    .rdata(ram_rdata)
  );

  // Search sequencer and result register.
  nss_search u_search (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .cfg      (cfg_r),
    .ram_req  (ram_req),
    .ram_rdata(ram_rdata),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  // A word is only taken when no result is being formed.
  a_no_result_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("result appeared the cycle after a word was accepted");

  // A miss reports slot zero.
  a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.found) |-> (out_word.match_index == '0))
    else $error("miss with non-zero match index");

  // A miss carries either the out-of-window or the no-entry offset.
  a_miss_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.found) |->
      ((out_word.offset == '0) || (out_word.offset == '1)))
    else $error("miss with an unexpected offset");

endmodule

>>> test/nss_lookup_checker.sv
`timescale 1ns / 100ps

// Watches the load/query, result and register ports of the symbol search
// block, keeps its own copy of the address table and registers, predicts
// the answer to every accepted query and compares it with the result words.
module nss_lookup_checker
  import nss_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  in_word_t             in_word,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  out_word_t            out_word,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_wdata,
  output int                   lookup_failures,
  output int                   lookups_waiting,
  output int                   lookups_compared
);

  localparam int REPORT_LIMIT = 10;

  // Shadow copy of the address table and of the three registers.
  logic [ADDR_W-1:0]  symbol_addr [TABLE_DEPTH];
  logic [COUNT_W-1:0] entry_count_q;
  logic [ADDR_W-1:0]  text_start_q;
  logic [ADDR_W-1:0]  text_end_q;

  // Answers still owed by the block, oldest first.
  out_word_t awaited_lookups [$];
  int        failures;
  int        compared;

  // Nearest entry at or below the query; the lowest slot wins a tie.
  function automatic out_word_t nearest_symbol(input logic [ADDR_W-1:0] query);
    out_word_t         answer;
    int                limit;
    logic [ADDR_W-1:0] distance;
    logic              hit;
    answer = '0;
    if (query < text_start_q || query >= text_end_q) return answer;
    limit = (entry_count_q > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count_q);
    hit = 1'b0;
    answer.offset = '1;
    for (int i = 0; i < limit; i++) begin
      if (symbol_addr[i] <= query) begin
        distance = query - symbol_addr[i];
        if (!hit || distance < answer.offset) begin
          hit = 1'b1;
          answer.match_index = ENTRY_IDX_W'(i);
          answer.offset = distance;
        end
      end
    end
    answer.found = hit;
    return answer;
  endfunction

  always @(posedge clk) begin : watch
    out_word_t want;
    if (!rst_n) begin
      entry_count_q = '0;
      text_start_q = '0;
      text_end_q = '0;
      awaited_lookups.delete();
    end else begin
      // Register writes take effect at once.
      if (cfg_we) begin
        case (cfg_index)
          REG_ENTRY_COUNT: entry_count_q = cfg_wdata[COUNT_W-1:0];
          REG_TEXT_START:  text_start_q = cfg_wdata;
          REG_TEXT_END:    text_end_q = cfg_wdata;
          default: ;
        endcase
      end

      // A result word is matched against the oldest outstanding query.
      if (out_valid && !out_stall) begin
        if (awaited_lookups.size() == 0) begin
          failures++;
          if (failures <= REPORT_LIMIT)
            $display("%0t: result word with no query outstanding: %s found=%0b index=%0d offset=%h",
                     $time, "", out_word.found, out_word.match_index, out_word.offset);
        end else begin
          want = awaited_lookups.pop_front();
          compared++;
          if (out_word.found !== want.found || out_word.match_index !== want.match_index ||
              out_word.offset !== want.offset) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
              $display("%0t: lookup mismatch: expected found=%0b index=%0d offset=%h,",
                       $time, want.found, want.match_index, want.offset);
              $display("    got found=%0b index=%0d offset=%h",
                       out_word.found, out_word.match_index, out_word.offset);
            end
          end
        end
      end

      // A load word updates the table, a query word owes one answer.
      if (in_valid && !in_stall) begin
        if (in_word.op == OP_LOAD) begin
          symbol_addr[in_word.entry_index] = in_word.entry_address;
        end else begin
          awaited_lookups.push_back(nearest_symbol(in_word.query_address));
        end
      end
    end
    lookup_failures <= failures;
    lookups_waiting <= awaited_lookups.size();
    lookups_compared <= compared;
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import nss_pkg::*;

  localparam int CYCLE_LIMIT     = 10_000_000;
  localparam int RANDOM_WORDS    = 580;
  localparam int SETTLE_CYCLES   = 8;
  localparam int TAIL_CYCLES     = 1100;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [ADDR_W-1:0]    ALL_ONES  = '1;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_word_t             in_word = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_word;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0]    cfg_wdata = '0;

  int lookup_failures;
  int lookups_waiting;
  int lookups_compared;

  // Stimulus bookkeeping.
  bit                written [TABLE_DEPTH];
  bit                burst = 1'b0;
  int                hold_req = 0;
  int                loads_sent = 0;
  int                queries_sent = 0;
  int                reg_writes = 0;
  int                random_words = 0;
  int                cycles = 0;
  logic [ADDR_W-1:0] cluster_base = '0;

  always #5 clk = ~clk;

  nearest_symbol_search uut (
    .clk, .rst_n, .in_valid, .in_stall, .in_word,
    .out_valid, .out_stall, .out_word, .cfg_we, .cfg_index, .cfg_wdata
  );

  nss_lookup_checker u_lookup_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_word,
    .out_valid, .out_stall, .out_word, .cfg_we, .cfg_index, .cfg_wdata,
    .lookup_failures, .lookups_waiting, .lookups_compared
  );

  // Number of slots written without a gap from slot 0; queries never
  // search beyond it, so no unwritten slot is ever read.
  function automatic int written_prefix();
    int n;
    n = 0;
    while (n < TABLE_DEPTH && written[n]) n++;
    return n;
  endfunction

  // Symbol addresses mostly sit just above the cluster base, with a few
  // near-duplicates for ties and some drawn from the whole range.
  function automatic logic [ADDR_W-1:0] pick_entry_address();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 2) return cluster_base + $urandom_range(0, 15);
    if (roll < 7) return cluster_base + $urandom_range(0, 255);
    return $urandom;
  endfunction

  function automatic logic [ADDR_W-1:0] pick_query_address();
    int roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '0;
    if (roll == 1) return ALL_ONES;
    if (roll < 16) return cluster_base + $urandom_range(0, 511);
    return $urandom;
  endfunction

  // Offers one word after a random gap (none in burst mode) and returns at the edge that takes it.
  task automatic send_word(input in_word_t w);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (w.op == OP_LOAD) begin
      written[w.entry_index] = 1'b1;
      loads_sent++;
    end else begin
      queries_sent++;
    end
  endtask

  task automatic send_load(input int idx, input logic [ADDR_W-1:0] addr);
    in_word_t w;
    w.op = OP_LOAD;
    w.entry_index = ENTRY_IDX_W'(idx);
    w.entry_address = addr;
    w.query_address = $urandom;
    send_word(w);
  endtask

  task automatic send_query(input logic [ADDR_W-1:0] addr);
    in_word_t w;
    w.op = OP_QUERY;
    w.entry_index = ENTRY_IDX_W'($urandom_range(0, TABLE_DEPTH - 1));
    w.entry_address = $urandom;
    w.query_address = addr;
    send_word(w);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  // Withdraws the input, waits for every answer and lets the block go quiet.
  task automatic drain(input int extra);
    in_valid <= 1'b0;
    @(posedge clk);
    while (lookups_waiting != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // One register setting followed by a mix of loads and queries.
  task automatic random_phase();
    int                prefix;
    int                words;
    int                kind;
    int                idx;
    bit                slow;
    logic [ADDR_W-1:0] count_value;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    drain(SETTLE_CYCLES);
    prefix = written_prefix();
    case ($urandom_range(0, 3))
      0: cluster_base = $urandom_range(0, 255);
      1: cluster_base = ALL_ONES - $urandom_range(0, 511);
      default: cluster_base = $urandom;
    endcase

    // Full-depth scans are slow, so they are rare and short.
    slow = (prefix == TABLE_DEPTH) && ($urandom_range(0, 3) == 0);
    if (slow) begin
      case ($urandom_range(0, 2))
        0: count_value = TABLE_DEPTH;
        1: count_value = ALL_ONES;
        default: count_value = $urandom_range(65, TABLE_DEPTH);
      endcase
    end else begin
      count_value = $urandom_range(0, (prefix < 48) ? prefix : 48);
    end

    // Whole range, a window round the cluster, an empty window or anything.
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      lo = '0;
      hi = ALL_ONES;
    end else if (kind < 7) begin
      lo = cluster_base;
      hi = cluster_base + $urandom_range(16, 400);
    end else if (kind < 8) begin
      lo = $urandom;
      hi = lo - $urandom_range(0, 1000);
    end else begin
      lo = $urandom;
      hi = $urandom;
    end
    write_reg(REG_ENTRY_COUNT, count_value);
    write_reg(REG_TEXT_START, lo);
    write_reg(REG_TEXT_END, hi);

    burst = ($urandom_range(0, 3) == 0);
    words = slow ? 8 : 30;
    repeat (words) begin
      if ($urandom_range(0, 99) < 35) begin
        if ($urandom_range(0, 9) == 0) idx = $urandom_range(0, TABLE_DEPTH - 1);
        else idx = $urandom_range(0, (prefix + 3 < 63) ? prefix + 3 : 63);
        send_load(idx, pick_entry_address());
      end else begin
        send_query(pick_query_address());
      end
      random_words++;
    end
  endtask

  // Result side: a random stall after each word (none in burst mode), or a long hold-off on request.
  initial begin : result_sink
    int wait_left;
    wait_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) wait_left = burst ? 0 : $urandom_range(0, 7);
      if (hold_req > 0) begin
        out_stall <= 1'b1;
        repeat (hold_req) @(posedge clk);
        hold_req = 0;
        out_stall <= 1'b0;
      end else if (wait_left > 0) begin
        out_stall <= 1'b1;
        wait_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** nearest_symbol_search: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Loads under reset settings; the query falls in the empty reset window.
    send_load(0, 32'h0000_1800);
    send_load(1, 32'h0000_1400);
    send_load(2, 32'h0000_1800);
    send_load(3, 32'h0000_2400);
    send_load(4, 32'h0000_0000);
    send_load(5, ALL_ONES);
    send_query(32'h0000_1000);

    // Window edges, no entry below the query, a tie and an exact hit.
    drain(SETTLE_CYCLES);
    write_reg(REG_ENTRY_COUNT, 32'd4);
    write_reg(REG_TEXT_START, 32'h0000_1000);
    write_reg(REG_TEXT_END, 32'h0000_2000);
    write_reg(REG_SPARE, ALL_ONES);
    send_query(32'h0000_0FFF);
    send_query(32'h0000_2000);
    send_query(32'h0000_1000);
    send_query(32'h0000_1FFF);
    send_query(32'h0000_1400);
    send_query(32'h0000_17FF);

    // No entries to search at all.
    drain(SETTLE_CYCLES);
    write_reg(REG_ENTRY_COUNT, 32'd0);
    send_query(32'h0000_1800);

    // Whole address range, entries at both ends of it.
    drain(SETTLE_CYCLES);
    write_reg(REG_ENTRY_COUNT, 32'd6);
    write_reg(REG_TEXT_START, '0);
    write_reg(REG_TEXT_END, ALL_ONES);
    send_query('0);
    send_query(ALL_ONES - 1);
    send_query(ALL_ONES);

    // Inverted window with an oversized count: nothing is searched.
    drain(SETTLE_CYCLES);
    write_reg(REG_ENTRY_COUNT, ALL_ONES);
    write_reg(REG_TEXT_START, ALL_ONES);
    write_reg(REG_TEXT_END, '0);
    send_query(ALL_ONES);
    send_query('0);

    // Results held off for a long stretch while queries keep coming.
    drain(SETTLE_CYCLES);
    write_reg(REG_ENTRY_COUNT, 32'd6);
    write_reg(REG_TEXT_START, '0);
    write_reg(REG_TEXT_END, ALL_ONES);
    cluster_base = '0;
    burst = 1'b1;
    hold_req = HOLD_OFF_CYCLES;
    repeat (12) send_query(32'h0000_1000 + $urandom_range(0, 8191));

    // Random phases; half way through the whole table is filled so that
    // full-depth and oversized counts can be searched.
    while (random_words < RANDOM_WORDS) begin
      if (random_words >= RANDOM_WORDS / 2 && written_prefix() < TABLE_DEPTH) begin
        drain(SETTLE_CYCLES);
        burst = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++)
          send_load(i, ($urandom_range(0, 3) == 0) ? pick_entry_address() : $urandom);
      end
      random_phase();
    end

    drain(TAIL_CYCLES);
    $display("Sent %0d load words and %0d query words across %0d register writes.",
             loads_sent, queries_sent, reg_writes);
    $display("Compared %0d result words; %0d failures.", lookups_compared, lookup_failures);
    if (lookup_failures == 0) begin
      $display("** nearest_symbol_search: PASSED **");
    end else begin
      $display("** nearest_symbol_search: FAILED **");
    end
    $finish;
  end

endmodule
